@@ hdl/hpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

    localparam int AVERAGE_DEPTH_DEF = 3;

    localparam int TIME_W    = 32;
    localparam int MIN_W     = 20;
    localparam int MAG_W     = 8;
    localparam int RATIO_W   = 16;
    localparam int RPM_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // 60e6 / 256 is exact, so the Q8.8 scale folds into the numerator constant
    localparam int NUM_SCALE_W = 18;
    localparam logic [NUM_SCALE_W-1:0] RPM_NUM_SCALE = 18'd234375;
    localparam int NUM_W = NUM_SCALE_W + RATIO_W;
    localparam int DEN_W = TIME_W + MAG_W;

    localparam logic [TIME_W-1:0] GAP_ALWAYS_US = 32'd100000;
    localparam logic [TIME_W-1:0] TIMEOUT_US    = 32'd200000;
    localparam logic [RPM_W-1:0]  RPM_MAX       = 20'hFFFFF;

    localparam logic [MIN_W-1:0]   MIN_RESET   = 20'd6666;
    localparam logic [MAG_W-1:0]   MAG_RESET   = 8'd1;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNETS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RATIO  = 2'd2;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef struct packed {
        logic load_in;
        logic qualify;
        logic apply;
        logic avg_load;
        logic div_load;
        logic avg_store;
        logic mul;
        logic rpm_store;
        logic load_out;
    } hpr_cmd_t;

    typedef struct packed {
        logic avg_en;
        logic avg_done;
        logic div_done;
        logic avg_zero;
    } hpr_stat_t;

endpackage

`default_nettype wire

@@ hdl/hpr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hpr_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 40
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DVS_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DVS_W:0] rs;
    logic           ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rs       = {r_reg, q_reg[DVD_W-1]};
        ge       = (rs >= {1'b0, d_reg});
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            q_next   = {q_reg[DVD_W-2:0], ge};
            r_next   = ge ? DVS_W'(rs - {1'b0, d_reg}) : rs[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient = q_reg;
    assign done     = (cnt_reg == '0);

endmodule

`default_nettype wire

@@ hdl/hpr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hpr_dp #(
    parameter int AVERAGE_DEPTH = hpr_pkg::AVERAGE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hpr_pkg::hpr_cmd_t                cmd,
    output hpr_pkg::hpr_stat_t                    stat,
    input  wire logic                             opcode,
    input  wire logic [hpr_pkg::TIME_W-1:0]       event_time_us,
    input  wire logic                             cfg_we,
    input  wire logic [hpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic      [hpr_pkg::RPM_W-1:0]        rpm_value,
    output logic                                  pulse_accepted,
    output logic      [hpr_pkg::TIME_W-1:0]       average_period_us,
    output logic                                  stopped
);

    localparam int TW    = hpr_pkg::TIME_W;
    localparam int SUM_W = TW + $clog2(AVERAGE_DEPTH);
    localparam int POS_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int NUM_W = hpr_pkg::NUM_W;
    localparam int DEN_W = hpr_pkg::DEN_W;
    localparam int DVD_W = NUM_W;
    localparam int RPM_W = hpr_pkg::RPM_W;

    // sum / depth as sum * ceil(2^RCP_SH / depth) >> RCP_SH, exact for any sum
    localparam int RCP_SH = SUM_W + $clog2(AVERAGE_DEPTH);
    localparam int RCP_W  = RCP_SH + 1;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((65'd1 << RCP_SH) + 65'(AVERAGE_DEPTH - 1)) / 65'(AVERAGE_DEPTH));
    localparam int CHK_W  = 12;
    localparam int CHK_N  = (SUM_W + CHK_W - 1) / CHK_W;
    localparam int MX_W   = CHK_N * CHK_W;
    localparam int ACC_W  = RCP_W + MX_W;
    localparam int STEP_W = $clog2(CHK_N + 1);

    // configuration
    logic [hpr_pkg::MIN_W-1:0]   min_reg, min_next;
    logic [hpr_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [hpr_pkg::RATIO_W-1:0] ratio_reg, ratio_next;

    // tracking state
    logic [TW-1:0]    last_reg, last_next;
    logic [TW-1:0]    prev_reg, prev_next;
    logic [TW-1:0]    ring_reg [AVERAGE_DEPTH];
    logic [TW-1:0]    ring_next [AVERAGE_DEPTH];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [RPM_W-1:0] rpm_reg, rpm_next;
    logic [TW-1:0]    avg_reg, avg_next;

    // per-request scratch
    logic             opc_reg, opc_next;
    logic [TW-1:0]    time_reg, time_next;
    logic [TW-1:0]    gap_reg, gap_next;
    logic             acc_reg, acc_next;
    logic             aen_reg, aen_next;
    logic             tmo_reg, tmo_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;

    // average by reciprocal multiply, one sum chunk per cycle
    logic [MX_W-1:0]   mx_reg, mx_next;
    logic [ACC_W-1:0]  macc_reg, macc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RCP_W+CHK_W-1:0] rcp_prod;

    logic [RPM_W-1:0] rpm_out_reg, rpm_out_next;
    logic             acc_out_reg, acc_out_next;
    logic [TW-1:0]    avg_out_reg, avg_out_next;
    logic             tmo_out_reg, tmo_out_next;

    logic [TW-1:0]    gap;
    logic [TW+2:0]    gap5;
    logic [TW+2:0]    prev2;
    logic             too_short;
    logic             too_fast;
    logic             take;
    logic [hpr_pkg::MAG_W-1:0] mag_eff;

    logic             div_load;
    logic [DVD_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic [DVD_W-1:0] div_quotient;
    logic             div_done;

    hpr_div #(
        .DVD_W (DVD_W),
        .DVS_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign div_load     = cmd.div_load;
    assign div_dividend = num_reg;
    assign div_divisor  = den_reg;

    // gap < floor(2*prev/5)  <=>  5*gap + 5 <= 2*prev
    always_comb
    begin
        gap       = time_reg - last_reg;
        gap5      = ({3'b000, gap} << 2) + {3'b000, gap} + (TW+3)'(5);
        prev2     = {2'b00, prev_reg, 1'b0};
        too_short = (gap < TW'(min_reg));
        too_fast  = (prev_reg != '0) && (gap5 <= prev2);
        take      = (opc_reg == hpr_pkg::OP_EDGE)
                    && ((gap > hpr_pkg::GAP_ALWAYS_US) || (!too_short && !too_fast));
        mag_eff   = (mag_reg == '0) ? hpr_pkg::MAG_W'(1) : mag_reg;
        rcp_prod  = (RCP_W+CHK_W)'(RECIP) * (RCP_W+CHK_W)'(mx_reg[MX_W-1 -: CHK_W]);
    end

    always_comb
    begin
        min_next     = min_reg;
        mag_next     = mag_reg;
        ratio_next   = ratio_reg;
        last_next    = last_reg;
        prev_next    = prev_reg;
        ring_next    = ring_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        rpm_next     = rpm_reg;
        avg_next     = avg_reg;
        opc_next     = opc_reg;
        time_next    = time_reg;
        gap_next     = gap_reg;
        acc_next     = acc_reg;
        aen_next     = aen_reg;
        tmo_next     = tmo_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mx_next      = mx_reg;
        macc_next    = macc_reg;
        step_next    = step_reg;
        rpm_out_next = rpm_out_reg;
        acc_out_next = acc_out_reg;
        avg_out_next = avg_out_reg;
        tmo_out_next = tmo_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                hpr_pkg::CFG_MIN_INTERVAL: min_next   = cfg_data[hpr_pkg::MIN_W-1:0];
                hpr_pkg::CFG_MAGNETS:      mag_next   = cfg_data[hpr_pkg::MAG_W-1:0];
                hpr_pkg::CFG_DRIVE_RATIO:  ratio_next = cfg_data[hpr_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load_in)
        begin
            opc_next  = opcode;
            time_next = event_time_us;
        end

        if (cmd.qualify)
        begin
            gap_next = gap;
            acc_next = take;
            aen_next = take && (gap > TW'(min_reg));
            tmo_next = (opc_reg == hpr_pkg::OP_POLL) && (gap > hpr_pkg::TIMEOUT_US);
            if (take)
            begin
                prev_next = gap;
                last_next = time_reg;
            end
        end

        if (cmd.apply)
        begin
            if (tmo_reg)
            begin
                for (int i = 0; i < AVERAGE_DEPTH; i++)
                begin
                    ring_next[i] = '0;
                end
                pos_next = '0;
                sum_next = '0;
                avg_next = '0;
                rpm_next = '0;
            end
            else if (aen_reg)
            begin
                if (rpm_reg == '0)
                begin
                    // prefill while stopped
                    for (int i = 0; i < AVERAGE_DEPTH; i++)
                    begin
                        ring_next[i] = gap_reg;
                    end
                    sum_next = SUM_W'(gap_reg) * SUM_W'(AVERAGE_DEPTH);
                end
                else
                begin
                    ring_next[pos_reg] = gap_reg;
                    sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(gap_reg);
                    pos_next = (pos_reg == POS_W'(AVERAGE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                end
            end
        end

        if (cmd.avg_load)
        begin
            mx_next   = MX_W'(sum_reg);
            macc_next = '0;
            step_next = STEP_W'(CHK_N);
        end
        else if (step_reg != '0)
        begin
            macc_next = (macc_reg << CHK_W) + ACC_W'(rcp_prod);
            mx_next   = mx_reg << CHK_W;
            step_next = step_reg - 1'b1;
        end

        if (cmd.avg_store)
        begin
            avg_next = macc_reg[RCP_SH +: TW];
        end

        if (cmd.mul)
        begin
            num_next = NUM_W'(hpr_pkg::RPM_NUM_SCALE) * NUM_W'(ratio_reg);
            den_next = DEN_W'(avg_reg) * DEN_W'(mag_eff);
        end

        if (cmd.rpm_store)
        begin
            rpm_next = (div_quotient[DVD_W-1:RPM_W] != '0) ? hpr_pkg::RPM_MAX
                                                          : div_quotient[RPM_W-1:0];
        end

        if (cmd.load_out)
        begin
            rpm_out_next = rpm_reg;
            acc_out_next = acc_reg;
            avg_out_next = avg_reg;
            tmo_out_next = tmo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= hpr_pkg::MIN_RESET;
            mag_reg   <= hpr_pkg::MAG_RESET;
            ratio_reg <= hpr_pkg::RATIO_RESET;
            last_reg  <= '0;
            prev_reg  <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg   <= '0;
            sum_reg   <= '0;
            rpm_reg   <= '0;
            avg_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            min_reg   <= min_next;
            mag_reg   <= mag_next;
            ratio_reg <= ratio_next;
            last_reg  <= last_next;
            prev_reg  <= prev_next;
            ring_reg  <= ring_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            rpm_reg   <= rpm_next;
            avg_reg   <= avg_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg     <= opc_next;
        time_reg    <= time_next;
        gap_reg     <= gap_next;
        acc_reg     <= acc_next;
        aen_reg     <= aen_next;
        tmo_reg     <= tmo_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        mx_reg      <= mx_next;
        macc_reg    <= macc_next;
        rpm_out_reg <= rpm_out_next;
        acc_out_reg <= acc_out_next;
        avg_out_reg <= avg_out_next;
        tmo_out_reg <= tmo_out_next;
    end

    assign stat.avg_en   = aen_reg && !tmo_reg;
    assign stat.avg_done = (step_reg == '0);
    assign stat.div_done = div_done;
    assign stat.avg_zero = (avg_reg == '0);

    assign rpm_value         = rpm_out_reg;
    assign pulse_accepted    = acc_out_reg;
    assign average_period_us = avg_out_reg;
    assign stopped           = tmo_out_reg;

endmodule

`default_nettype wire

@@ hdl/hpr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hpr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output hpr_pkg::hpr_cmd_t       cmd,
    input  wire hpr_pkg::hpr_stat_t stat
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_QUAL    = 4'd1;
    localparam logic [3:0] S_APPLY   = 4'd2;
    localparam logic [3:0] S_AVG_LD  = 4'd3;
    localparam logic [3:0] S_AVG_RUN = 4'd4;
    localparam logic [3:0] S_MUL     = 4'd5;
    localparam logic [3:0] S_RPM_LD  = 4'd6;
    localparam logic [3:0] S_RPM_RUN = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_QUAL;
                end
            end
            S_QUAL:
            begin
                cmd.qualify = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = stat.avg_en ? S_AVG_LD : S_FIN;
            end
            S_AVG_LD:
            begin
                cmd.avg_load = 1'b1;
                state_next   = S_AVG_RUN;
            end
            S_AVG_RUN:
            begin
                if (stat.avg_done)
                begin
                    cmd.avg_store = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = stat.avg_zero ? S_FIN : S_RPM_LD;
            end
            S_RPM_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_RPM_RUN;
            end
            S_RPM_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.rpm_store = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/hall_pulse_rpm_meter_core.sv @@
// Hall-sensor tachometer: qualifies pulse intervals, keeps a moving average
// of AVERAGE_DEPTH intervals and derives engine rpm from it.
// Input channel (in_valid/in_stall): opcode 0 is a hall edge, 1 a timeout
// poll; event_time_us is the free-running microsecond stamp of the request.
// Output channel (out_valid/out_stall): exactly one result per request, in
// order: rpm_value, pulse_accepted, average_period_us, stopped.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 minimum pulse
// interval, 1 magnet count, 2 drive ratio Q8.8; other indexes are ignored.
// Write it only while no request is in flight.
// A poll or an edge that does not enter the average passes through the
// qualify and apply steps to the output register. An averaged edge divides the
// sum by the depth with a reciprocal multiply, 12 sum bits per cycle (3 steps
// at depth 3), then, unless the average is zero, runs a radix-2 divider for
// rpm, one bit per cycle over the 34-bit numerator. One request is worked at
// a time; the next is accepted the cycle after the result moves to the output
// register, and a stalled result holds the following request in its last step.
// Reset clears rpm, the average and the pulse history and loads the default
// configuration; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

module hall_pulse_rpm_meter_core #(
    parameter int AVERAGE_DEPTH = hpr_pkg::AVERAGE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic [hpr_pkg::TIME_W-1:0]     event_time_us,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [hpr_pkg::RPM_W-1:0]      rpm_value,
    output logic                                pulse_accepted,
    output logic      [hpr_pkg::TIME_W-1:0]     average_period_us,
    output logic                                stopped,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    hpr_pkg::hpr_cmd_t  cmd;
    hpr_pkg::hpr_stat_t stat;

    assign cfg_ready = 1'b1;

    hpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    hpr_dp #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .opcode            (opcode),
        .event_time_us     (event_time_us),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .rpm_value         (rpm_value),
        .pulse_accepted    (pulse_accepted),
        .average_period_us (average_period_us),
        .stopped           (stopped)
    );

endmodule

`default_nettype wire
